/* rtl/core/multithread_issue_scheduler_macros.svh */
// ============================================================================
// Assertion macros for the multithread issue scheduler
// Shorthand for clocked implication checks with a synchronous reset gate.
// ============================================================================
`ifndef MULTITHREAD_ISSUE_SCHEDULER_MACROS_SVH
`define MULTITHREAD_ISSUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MIS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define MIS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

/* rtl/core/mis_pkg.sv */
// ============================================================================
// Multithread issue scheduler package
// Shared codes, reset values and controller/datapath interface types.
// ============================================================================
`default_nettype none

package mis_pkg;

    // Default number of hardware thread slots.
    localparam int MAX_THREADS_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_THREAD_COUNT = 3'd1,
        CFG_LD_DELAY     = 3'd2,
        CFG_ST_DELAY     = 3'd3,
        CFG_SWITCH       = 3'd4
    } cfg_index_t;

    // Configuration reset values.
    localparam logic        MODE_RST          = 1'b0;
    localparam logic [3:0]  THREAD_COUNT_RST  = 4'd4;
    localparam logic [9:0]  LD_DELAY_RST      = 10'd4;
    localparam logic [9:0]  ST_DELAY_RST      = 10'd4;
    localparam logic [9:0]  SWITCH_CYCLES_RST = 10'd2;

    // Mode codes.
    localparam logic MODE_BLOCKED = 1'b0;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_IDLE   = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_ISSUE  = 2'd2,
        ACT_DONE   = 2'd3
    } action_t;

    // Pending instruction classes.
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_LOAD  = 2'd1,
        CLS_STORE = 2'd2,
        CLS_HALT  = 2'd3
    } class_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic norm_step;
        logic commit;
    } mis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_ok;
        logic out_free;
    } mis_sts_t;

endpackage

`default_nettype wire

/* rtl/core/mis_ctrl.sv */
// ============================================================================
// Multithread issue scheduler controller
// Sequences request capture, search start normalization and commit.
// ============================================================================
`default_nettype none

module mis_ctrl
    import mis_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mis_sts_t sts,
    output mis_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_ISSUE
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    // Commands are decoded from the current state, the input valid and the status inputs.
    always_comb begin
        cmd.capture   = s_valid && s_ready_reg;
        cmd.norm_step = (state_reg == ST_NORM) && !sts.start_ok;
        cmd.commit    = (state_reg == ST_ISSUE) && sts.out_free;
    end

    // State and the registered input ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_NORM;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_NORM: begin
                    if (sts.start_ok) begin
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (sts.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

/* rtl/core/mis_dp.sv */
// ============================================================================
// Multithread issue scheduler datapath
// Thread state, readiness check, round-robin pick, counters and result register.
// ============================================================================
`default_nettype none

`include "multithread_issue_scheduler_macros.svh"

module mis_dp
    import mis_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [15:0]           s_pending_classes,
    input  wire mis_cmd_t              cmd,
    output mis_sts_t                   sts,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [1:0]                 m_action,
    output logic [2:0]                 m_chosen_thread,
    output logic [31:0]                m_fetch_index,
    output logic [31:0]                m_cycle_total,
    output logic [31:0]                m_issued_total
);

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int NW = $clog2(MAX_THREADS + 1);

    // Configuration registers.
    logic       mode_reg;
    logic [3:0] thread_count_reg;
    logic [9:0] ld_delay_reg;
    logic [9:0] st_delay_reg;
    logic [9:0] switch_cycles_reg;

    // Architectural scheduler state.
    logic [31:0]   cycle_reg;
    logic [31:0]   issued_reg;
    logic [TW-1:0] search_start_reg;
    logic          halted_reg     [MAX_THREADS];
    logic          started_reg    [MAX_THREADS];
    class_t        last_class_reg [MAX_THREADS];
    logic [31:0]   last_cycle_reg [MAX_THREADS];
    logic [31:0]   pc_reg         [MAX_THREADS];

    // Per-request working registers.
    logic [15:0]          pend_reg;
    logic [MAX_THREADS-1:0] ready_reg;
    logic                 live_reg;
    logic [TW-1:0]        start_reg;

    // Result register.
    logic        m_valid_reg;
    action_t     m_action_reg;
    logic [2:0]  m_chosen_reg;
    logic [31:0] m_fetch_reg;

    // Combinational intermediates.
    logic [NW-1:0]          n_eff;
    logic [MAX_THREADS-1:0] ready_vec;
    logic [MAX_THREADS-1:0] live_vec;
    logic [31:0]            age;
    logic [TW-1:0]          hi_idx;
    logic [TW-1:0]          lo_idx;
    logic                   hi_found;
    logic                   found;
    logic [TW-1:0]          chosen;
    class_t                 cls;
    action_t                act;
    logic [31:0]            fetch;
    logic [31:0]            cycle_next;
    logic [31:0]            issued_next;
    logic [TW-1:0]          next_start;
    logic                   done_shown;

    // Threads in use: zero acts as one, large counts clamp to the slot count.
    always_comb begin
        if (thread_count_reg == 4'd0) begin
            n_eff = NW'(1);
        end else if (32'(thread_count_reg) > MAX_THREADS) begin
            n_eff = NW'(MAX_THREADS);
        end else begin
            n_eff = NW'(thread_count_reg);
        end
    end

    // Readiness of every thread, from its last load or store and its age.
    always_comb begin
        age = '0;
        for (int t = 0; t < MAX_THREADS; t++) begin
            age          = cycle_reg - last_cycle_reg[t];
            live_vec[t]  = (t < 32'(n_eff)) && !halted_reg[t];
            ready_vec[t] = live_vec[t];
            if (live_vec[t] && started_reg[t]) begin
                case (last_class_reg[t])
                    CLS_LOAD:  ready_vec[t] = age > 32'(ld_delay_reg);
                    CLS_STORE: ready_vec[t] = age > 32'(st_delay_reg);
                    default:   ready_vec[t] = 1'b1;
                endcase
            end
        end
    end

    // Round-robin pick: first ready thread at or after the start, else first overall.
    always_comb begin
        hi_idx   = '0;
        lo_idx   = '0;
        hi_found = 1'b0;
        for (int t = MAX_THREADS - 1; t >= 0; t--) begin
            if (ready_reg[t]) begin
                lo_idx = TW'(t);
                if (t >= 32'(start_reg)) begin
                    hi_idx   = TW'(t);
                    hi_found = 1'b1;
                end
            end
        end
        found  = |ready_reg;
        chosen = hi_found ? hi_idx : lo_idx;
    end

    // Class of the chosen thread's pending instruction; slots past eight see other.
    always_comb begin
        cls = CLS_OTHER;
        for (int k = 0; k < 8; k++) begin
            if (32'(chosen) == k) begin
                cls = class_t'(pend_reg[2*k +: 2]);
            end
        end
    end

    // Outcome of the step and the next counter values.
    always_comb begin
        act         = ACT_IDLE;
        fetch       = '0;
        cycle_next  = cycle_reg + 32'd1;
        issued_next = issued_reg;
        if (32'(chosen) + 32'd1 == 32'(n_eff)) begin
            next_start = '0;
        end else begin
            next_start = TW'(32'(chosen) + 32'd1);
        end
        if (!live_reg) begin
            act        = ACT_DONE;
            cycle_next = cycle_reg;
        end else if (!found) begin
            act = ACT_IDLE;
        end else if (mode_reg == MODE_BLOCKED && chosen != search_start_reg) begin
            act        = ACT_SWITCH;
            cycle_next = cycle_reg + 32'(switch_cycles_reg);
        end else begin
            act         = ACT_ISSUE;
            issued_next = issued_reg + 32'd1;
            fetch       = (cls == CLS_HALT) ? pc_reg[chosen] : pc_reg[chosen] + 32'd1;
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.start_ok = 32'(start_reg) < 32'(n_eff);
        sts.out_free = !m_valid_reg || m_ready;
    end

    // Request capture and search start normalization (one subtract a cycle).
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pend_reg  <= s_pending_classes;
            ready_reg <= ready_vec;
            live_reg  <= |live_vec;
            start_reg <= search_start_reg;
        end else if (cmd.norm_step) begin
            start_reg <= TW'(32'(start_reg) - 32'(n_eff));
        end
    end

    // Issue cycle stamps hold no reset value; they are read only once written.
    always_ff @(posedge aclk) begin
        if (cmd.commit && act == ACT_ISSUE && cls != CLS_HALT) begin
            last_cycle_reg[chosen] <= cycle_reg;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_action_reg <= act;
            m_chosen_reg <= (act == ACT_SWITCH || act == ACT_ISSUE) ? 3'(chosen) : 3'd0;
            m_fetch_reg  <= fetch;
        end
    end

    // Configuration writes, thread state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_RST;
            thread_count_reg  <= THREAD_COUNT_RST;
            ld_delay_reg      <= LD_DELAY_RST;
            st_delay_reg      <= ST_DELAY_RST;
            switch_cycles_reg <= SWITCH_CYCLES_RST;
            cycle_reg         <= '0;
            issued_reg        <= '0;
            search_start_reg  <= '0;
            m_valid_reg       <= 1'b0;
            for (int t = 0; t < MAX_THREADS; t++) begin
                halted_reg[t]     <= 1'b0;
                started_reg[t]    <= 1'b0;
                last_class_reg[t] <= CLS_OTHER;
                pc_reg[t]         <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MODE:         mode_reg          <= cfg_wdata[0];
                    CFG_THREAD_COUNT: thread_count_reg  <= cfg_wdata[3:0];
                    CFG_LD_DELAY:     ld_delay_reg      <= cfg_wdata;
                    CFG_ST_DELAY:     st_delay_reg      <= cfg_wdata;
                    CFG_SWITCH:       switch_cycles_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.commit) begin
                cycle_reg  <= cycle_next;
                issued_reg <= issued_next;
                if (act == ACT_SWITCH) begin
                    search_start_reg <= chosen;
                end
                if (act == ACT_ISSUE) begin
                    if (cls == CLS_HALT) begin
                        halted_reg[chosen] <= 1'b1;
                    end else begin
                        pc_reg[chosen]         <= fetch;
                        last_class_reg[chosen] <= cls;
                        started_reg[chosen]    <= 1'b1;
                    end
                    if (mode_reg != MODE_BLOCKED) begin
                        search_start_reg <= next_start;
                    end
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = m_action_reg;
    assign m_chosen_thread = m_chosen_reg;
    assign m_fetch_index   = m_fetch_reg;
    assign m_cycle_total   = cycle_reg;
    assign m_issued_total  = issued_reg;

    // A pending all-halted result.
    assign done_shown = m_valid_reg && m_action_reg == ACT_DONE;

    // A commit always sees a search start inside the threads in use.
    `MIS_ASSERT_IMP(a_commit_start_norm, aclk, aresetn, cmd.commit, 32'(start_reg) < 32'(n_eff))
    // Normalization only steps while the start is still out of range.
    `MIS_ASSERT_IMP(a_norm_needed, aclk, aresetn, cmd.norm_step, 32'(start_reg) >= 32'(n_eff))
    // A committed step shows up as a pending result in the next cycle.
    `MIS_ASSERT_NXT(a_commit_shows, aclk, aresetn, cmd.commit, m_valid_reg)
    // An all-halted result names no thread and no fetch index.
    `MIS_ASSERT_IMP(a_done_clean, aclk, aresetn, done_shown, m_chosen_reg == 3'd0 && m_fetch_reg == 32'd0)

endmodule

`default_nettype wire

/* rtl/core/multithread_issue_scheduler.sv */
// ============================================================================
// Multithread issue scheduler
// Picks the issuing thread each step in blocked or fine-grained mode.
// ============================================================================
//
//   Channel   Handshake           Carries
//   s_        s_valid / s_ready   pending_classes, one request per step
//   m_        m_valid / m_ready   action, chosen_thread, fetch_index, totals
//   cfg_      cfg_wr_en           register index and write data, no wait
//
// A request passes through capture with the readiness check, a search start
// check, and the pick and commit. When the stored search start is at or
// beyond the threads in use, it is normalized first, one subtract of the thread
// count per cycle.
// Reset is synchronous, active low; resets config, counters and thread state.
// The result register frees the input side: a new request is taken while a
// result waits, and the commit stalls only while a full result is not taken.
// ============================================================================
`default_nettype none

module multithread_issue_scheduler
    import mis_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [15:0]           s_pending_classes,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_action,
    output logic [2:0]                 m_chosen_thread,
    output logic [31:0]                m_fetch_index,
    output logic [31:0]                m_cycle_total,
    output logic [31:0]                m_issued_total
);

    mis_cmd_t cmd;
    mis_sts_t sts;

    // Step sequencer.
    mis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Thread state and pick logic.
    mis_dp #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_pending_classes (s_pending_classes),
        .cmd               (cmd),
        .sts               (sts),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_action          (m_action),
        .m_chosen_thread   (m_chosen_thread),
        .m_fetch_index     (m_fetch_index),
        .m_cycle_total     (m_cycle_total),
        .m_issued_total    (m_issued_total)
    );

endmodule

`default_nettype wire

/* tb/tb_multithread_issue_scheduler.sv */
// ============================================================================
// Testbench for the multithread issue scheduler
// Sends scheduling requests through the valid/ready input channel, predicts
// every result with a cycle-free model of the thread selector, and compares
// each result field by field. It covers blocked and fine-grained modes,
// thread counts outside the legal range, latency and switch-cost extremes,
// an out-of-range search start, and a closing phase that halts every thread.
// ============================================================================
`default_nettype none

import mis_pkg::*;

// One scheduling result as it leaves the block.
typedef struct packed {
    action_t     action;
    logic [2:0]  thread;
    logic [31:0] fetch;
    logic [31:0] cycles;
    logic [31:0] issued;
} sched_result_t;

// Thread selector model plus the queue of results it still expects.
class sched_scoreboard;
    // Register copy.
    logic        mode;
    logic [3:0]  thread_count;
    logic [9:0]  ld_delay;
    logic [9:0]  st_delay;
    logic [9:0]  switch_cost;

    // Scheduler state.
    logic [31:0] cycle_count;
    logic [31:0] issued_count;
    int unsigned search_start;
    bit          halted [MAX_THREADS_DEF];
    bit          started[MAX_THREADS_DEF];
    class_t      last_class[MAX_THREADS_DEF];
    logic [31:0] last_issue[MAX_THREADS_DEF];
    logic [31:0] thread_pc [MAX_THREADS_DEF];

    sched_result_t expected_picks[$];
    int            mismatches;
    int            action_seen[4];

    function new();
        mode         = MODE_RST;
        thread_count = THREAD_COUNT_RST;
        ld_delay     = LD_DELAY_RST;
        st_delay     = ST_DELAY_RST;
        switch_cost  = SWITCH_CYCLES_RST;
        cycle_count  = '0;
        issued_count = '0;
        search_start = 0;
        mismatches   = 0;
        for (int t = 0; t < MAX_THREADS_DEF; t++) begin
            halted[t]     = 1'b0;
            started[t]    = 1'b0;
            last_class[t] = CLS_OTHER;
            last_issue[t] = '0;
            thread_pc[t]  = '0;
        end
        for (int a = 0; a < 4; a++) action_seen[a] = 0;
    endfunction

    // Only the low bits that each register holds are kept.
    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:         mode         = data[0];
            CFG_THREAD_COUNT: thread_count = data[3:0];
            CFG_LD_DELAY:     ld_delay     = data[9:0];
            CFG_ST_DELAY:     st_delay     = data[9:0];
            CFG_SWITCH:       switch_cost  = data[9:0];
            default: ;
        endcase
    endfunction

    // A thread waits out the latency of its last load or store.
    function bit thread_ready(int t);
        logic [31:0] age;
        if (halted[t]) return 1'b0;
        if (!started[t]) return 1'b1;
        age = cycle_count - last_issue[t];
        case (last_class[t])
            CLS_LOAD:  return age > 32'(ld_delay);
            CLS_STORE: return age > 32'(st_delay);
            default:   return 1'b1;
        endcase
    endfunction

    // One scheduling step: round-robin search, then switch or issue.
    function sched_result_t pick_thread(logic [15:0] pend);
        sched_result_t r;
        int            n;
        int            i;
        int            t;
        int            chosen;
        bit            any_live;
        bit            found;
        class_t        cls;
        n = (thread_count == 0) ? 1 :
            (thread_count > MAX_THREADS_DEF) ? MAX_THREADS_DEF : int'(thread_count);
        r.action = ACT_IDLE;
        r.thread = '0;
        r.fetch  = '0;
        chosen   = 0;
        any_live = 1'b0;
        found    = 1'b0;
        for (t = 0; t < n; t++) begin
            if (!halted[t]) any_live = 1'b1;
        end
        if (!any_live) begin
            r.action = ACT_DONE;
        end else begin
            for (i = 0; i < n && !found; i++) begin
                t = int'((search_start + i) % n);
                if (thread_ready(t)) begin
                    chosen = t;
                    found  = 1'b1;
                end
            end
            if (!found) begin
                cycle_count++;
            end else if (mode == MODE_BLOCKED && chosen != search_start) begin
                // Blocked mode pays for the switch and issues nothing.
                r.action     = ACT_SWITCH;
                r.thread     = chosen[2:0];
                search_start = chosen;
                cycle_count  = cycle_count + 32'(switch_cost);
            end else begin
                cls = class_t'(pend[2*chosen +: 2]);
                r.action = ACT_ISSUE;
                r.thread = chosen[2:0];
                issued_count++;
                if (cls == CLS_HALT) begin
                    halted[chosen] = 1'b1;
                end else begin
                    thread_pc[chosen]++;
                    last_issue[chosen] = cycle_count;
                    last_class[chosen] = cls;
                    started[chosen]    = 1'b1;
                end
                r.fetch = thread_pc[chosen];
                if (mode != MODE_BLOCKED) search_start = (chosen + 1) % n;
                cycle_count++;
            end
        end
        r.cycles = cycle_count;
        r.issued = issued_count;
        action_seen[int'(r.action)]++;
        return r;
    endfunction

    function void note_request(logic [15:0] pend);
        expected_picks.push_back(pick_thread(pend));
    endfunction

    function void check_result(sched_result_t got);
        sched_result_t want;
        string         bad;
        if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result with no request pending: action=%0d thread=%0d",
                         got.action, got.thread);
            return;
        end
        want = expected_picks.pop_front();
        bad  = "";
        if (got.action !== want.action) bad = {bad, " action"};
        if (got.thread !== want.thread) bad = {bad, " chosen_thread"};
        if (got.fetch  !== want.fetch)  bad = {bad, " fetch_index"};
        if (got.cycles !== want.cycles) bad = {bad, " cycle_total"};
        if (got.issued !== want.issued) bad = {bad, " issued_total"};
        if (bad != "") begin
            mismatches++;
            // Values are listed as action/thread/fetch/cycles/issued.
            if (mismatches <= 10)
                $display("Mismatch in%s: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                         bad, want.action, want.thread, want.fetch, want.cycles,
                         want.issued, got.action, got.thread, got.fetch, got.cycles,
                         got.issued);
        end
    endfunction
endclass

module tb_multithread_issue_scheduler;

    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_pending_classes = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [1:0]            m_action;
    logic [2:0]            m_chosen_thread;
    logic [31:0]           m_fetch_index;
    logic [31:0]           m_cycle_total;
    logic [31:0]           m_issued_total;

    sched_scoreboard sb = new();

    int idle_pct      = 0;
    int stall_left    = 0;
    int cycle_no      = 0;
    int settings_used = 0;
    int requests_sent = 0;

    multithread_issue_scheduler u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pending_classes (s_pending_classes),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_chosen_thread   (m_chosen_thread),
        .m_fetch_index     (m_fetch_index),
        .m_cycle_total     (m_cycle_total),
        .m_issued_total    (m_issued_total)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_no, sb.expected_picks.size());
            $display("tb_multithread_issue_scheduler NOT OK");
            $finish;
        end
    end

    // Result side: check each accepted result and stall in random bursts.
    initial begin : result_sink
        sched_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.action = action_t'(m_action);
                got.thread = m_chosen_thread;
                got.fetch  = m_fetch_index;
                got.cycles = m_cycle_total;
                got.issued = m_issued_total;
                sb.check_result(got);
            end
            if (idle_pct == 0) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request, after an optional gap, and hold it until taken.
    task automatic send_request(input logic [15:0] classes);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_pending_classes <= classes;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(classes);
        requests_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_picks.size() != 0);
    endtask

    // Write all five registers, one per cycle; unused data bits are random.
    task automatic drive_setting(input logic md, input logic [3:0] tc,
                                 input logic [9:0] ld, input logic [9:0] st,
                                 input logic [9:0] sw);
        cfg_index_t            regs[5];
        logic [CFG_DATA_W-1:0] vals[5];
        int                    k;
        regs = '{CFG_MODE, CFG_THREAD_COUNT, CFG_LD_DELAY, CFG_ST_DELAY, CFG_SWITCH};
        vals = '{{9'($urandom), md}, {6'($urandom), tc}, ld, st, sw};
        for (k = 0; k < 5; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge aclk);
            sb.write_reg(regs[k], vals[k]);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Pending classes per thread; sometimes every thread gets the same one.
    function automatic logic [15:0] random_classes(input int halt_pct);
        logic [15:0] v;
        class_t      same;
        int          t;
        if ($urandom_range(0, 7) == 0) begin
            same = class_t'($urandom_range(0, 2));
            for (t = 0; t < 8; t++) v[2*t +: 2] = same;
        end else begin
            for (t = 0; t < 8; t++)
                v[2*t +: 2] = ($urandom_range(0, 99) < halt_pct) ? CLS_HALT
                                                                 : class_t'($urandom_range(0, 2));
        end
        return v;
    endfunction

    // Latency or switch cost, biased to short values with the extremes mixed in.
    function automatic logic [9:0] random_span();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1023;
            2:       return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(0, 10));
        endcase
    endfunction

    function automatic logic [3:0] random_thread_count();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    // Main sequence.
    initial begin : stimulus
        int ph;
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_pct = 20;

        // Reset defaults: blocked mode, four threads, short latencies.
        send_request(16'h0000);
        send_request(16'h5555);
        send_request(16'hAAAA);
        send_request(16'h0000);
        wait_drained();

        // Fine-grained with eight threads until the search start reaches seven.
        drive_setting(1'b1, 4'd8, 10'd0, 10'd0, 10'd0);
        for (k = 0; k < 10 && sb.search_start != 7; k++) send_request(random_classes(0));
        wait_drained();

        // Three threads in blocked mode, so the stored search start is out of range.
        drive_setting(1'b0, 4'd3, 10'd4, 10'd4, 10'd2);
        repeat (3) send_request(random_classes(0));
        wait_drained();

        // Thread count zero acts as one; a load blocks its thread for a long time.
        drive_setting(1'b0, 4'd0, 10'd1023, 10'd0, 10'd0);
        send_request(16'h0001);
        send_request(16'h0001);
        send_request(16'h0000);
        send_request(16'h0000);
        wait_drained();

        // Thread count above the maximum, every span at its top value.
        drive_setting(1'b0, 4'd15, 10'd1023, 10'd1023, 10'd1023);
        send_request(16'hAAAA);
        send_request(16'hAAAA);
        send_request(16'h5555);
        send_request(16'h0000);
        send_request(16'h0000);
        wait_drained();

        // Random settings with random requests; every third phase runs without gaps.
        for (ph = 0; ph < 10; ph++) begin
            drive_setting(1'($urandom), random_thread_count(), random_span(),
                          random_span(), random_span());
            idle_pct = (ph % 3 == 2) ? 0 : 25;
            repeat (60) send_request(random_classes(0));
            wait_drained();
        end

        // Closing phase, no idling: halt threads until all of them are done.
        idle_pct = 0;
        drive_setting(1'b0, 4'd8, 10'd2, 10'd3, 10'd1);
        repeat (30) send_request(random_classes(15));
        wait_drained();
        drive_setting(1'b1, 4'd8, 10'd0, 10'd0, 10'd0);
        repeat (30) send_request(random_classes(30));
        repeat (16) send_request(16'hFFFF);
        wait_drained();
        drive_setting(1'b0, 4'd0, 10'd0, 10'd0, 10'd0);
        repeat (3) send_request(random_classes(0));
        wait_drained();

        // Let any stray result show up before the verdict.
        repeat (40) @(posedge aclk);

        $display("Covered %0d requests over %0d register settings.",
                 requests_sent, settings_used);
        $display("Results: %0d issues, %0d switches, %0d idle steps, %0d all-halted steps.",
                 sb.action_seen[ACT_ISSUE], sb.action_seen[ACT_SWITCH],
                 sb.action_seen[ACT_IDLE], sb.action_seen[ACT_DONE]);
        if (sb.mismatches == 0 && sb.expected_picks.size() == 0) begin
            $display("tb_multithread_issue_scheduler OK");
        end else begin
            $display("%0d mismatches, %0d results missing.", sb.mismatches,
                     sb.expected_picks.size());
            $display("tb_multithread_issue_scheduler NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
